// ===== hw/rtl/pwsa_pkg.sv =====
// Shared types and constants for the perspective warp source address generator.
package pwsa_pkg;

  localparam int IMG_ROWS = 1024;
  localparam int IMG_COLS = 1024;

  localparam int COEF_W  = 48;
  localparam int COORD_W = 10;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 4;
  localparam int PROD_W  = COEF_W + COORD_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int MAG_W   = SUM_W;
  localparam int QUOT_W  = 12;
  localparam int SH_W    = MAG_W + QUOT_W;

  localparam logic [QUOT_W-1:0] ROW_LAST = QUOT_W'(IMG_ROWS - 1);
  localparam logic [QUOT_W-1:0] COL_LAST = QUOT_W'(IMG_COLS - 1);
  localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(64'sd4294967296);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_FROM_ROW   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_FROM_COL   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP_FROM_COL = 4'd7;

  typedef logic [NUM_REGS-1:0][COEF_W-1:0] pwsa_coef_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic dz;
    logic r_neg;
    logic c_neg;
    logic r_ovf;
    logic c_ovf;
  } pwsa_tag_t;

  typedef struct packed {
    pwsa_tag_t tag;
    logic [MAG_W-1:0] rem_r;
    logic [MAG_W-1:0] rem_c;
    logic [SH_W-1:0] dsh;
    logic [QUOT_W-1:0] q_r;
    logic [QUOT_W-1:0] q_c;
  } pwsa_div_t;

endpackage

// ===== hw/rtl/pwsa_front.sv =====
// Front stages: products, sums and sign/magnitude split ahead of the divider chain.
module pwsa_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [pwsa_pkg::COORD_W-1:0] row,
  input  logic [pwsa_pkg::COORD_W-1:0] col,
  input  pwsa_pkg::pwsa_coef_t      coef,
  output logic                      out_valid,
  output pwsa_pkg::pwsa_div_t       out_data
);
  import pwsa_pkg::*;

  logic v1, v2;
  logic [COORD_W-1:0] row1, col1, row2, col2;
  logic signed [PROD_W-1:0] prod [NUM_REGS];
  logic signed [SUM_W-1:0] den, num_r, num_c;
  logic signed [SUM_W-1:0] den_next, num_r_next, num_c_next;
  logic [MAG_W-1:0] mag_d, mag_r, mag_c;
  pwsa_div_t data_next;

  // Stage one: all six products in parallel.
  always_ff @(posedge clk) begin
    if (en) begin
      row1 <= row;
      col1 <= col;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == 2 || i == 5) begin
          prod[i] <= PROD_W'($signed(coef[i]));
        end else if (i == 0 || i == 3 || i == 6) begin
          prod[i] <= $signed(coef[i]) * $signed({1'b0, row});
        end else begin
          prod[i] <= $signed(coef[i]) * $signed({1'b0, col});
        end
      end
    end
  end

  always_comb begin
    num_r_next = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    num_c_next = SUM_W'(prod[3]) + SUM_W'(prod[4]) + SUM_W'(prod[5]);
    den_next   = SUM_W'(prod[6]) + SUM_W'(prod[7]) + Q_ONE;
  end

  // Stage two: the three sums.
  always_ff @(posedge clk) begin
    if (en) begin
      row2  <= row1;
      col2  <= col1;
      den   <= den_next;
      num_r <= num_r_next;
      num_c <= num_c_next;
    end
  end

  always_comb begin
    mag_d = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
    mag_r = num_r[SUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
    mag_c = num_c[SUM_W-1] ? MAG_W'(-num_c) : MAG_W'(num_c);
    data_next.tag.row   = row2;
    data_next.tag.col   = col2;
    data_next.tag.dz    = (den == '0);
    data_next.tag.r_neg = num_r[SUM_W-1] ^ den[SUM_W-1];
    data_next.tag.c_neg = num_c[SUM_W-1] ^ den[SUM_W-1];
    data_next.tag.r_ovf = {{QUOT_W{1'b0}}, mag_r} >= {mag_d, {QUOT_W{1'b0}}};
    data_next.tag.c_ovf = {{QUOT_W{1'b0}}, mag_c} >= {mag_d, {QUOT_W{1'b0}}};
    data_next.rem_r     = mag_r;
    data_next.rem_c     = mag_c;
    data_next.dsh       = SH_W'({mag_d, {(QUOT_W-1){1'b0}}});
    data_next.q_r       = '0;
    data_next.q_c       = '0;
  end

  // Stage three: magnitudes and range pre-checks.
  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== hw/rtl/pwsa_div_cell.sv =====
// One restoring division cell: resolves one quotient bit for both coordinates.
module pwsa_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  pwsa_pkg::pwsa_div_t in_data,
  output logic                out_valid,
  output pwsa_pkg::pwsa_div_t out_data
);
  import pwsa_pkg::*;

  logic ge_r, ge_c;
  pwsa_div_t data_next;

  always_comb begin
    ge_r = {{QUOT_W{1'b0}}, in_data.rem_r} >= in_data.dsh;
    ge_c = {{QUOT_W{1'b0}}, in_data.rem_c} >= in_data.dsh;
    data_next       = in_data;
    data_next.rem_r = ge_r ? in_data.rem_r - in_data.dsh[MAG_W-1:0] : in_data.rem_r;
    data_next.rem_c = ge_c ? in_data.rem_c - in_data.dsh[MAG_W-1:0] : in_data.rem_c;
    data_next.q_r   = {in_data.q_r[QUOT_W-2:0], ge_r};
    data_next.q_c   = {in_data.q_c[QUOT_W-2:0], ge_c};
    data_next.dsh   = in_data.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

endmodule

// ===== hw/rtl/perspective_warp_source_address.sv =====
// Top level of the perspective warp source address generator.
//
// Each input transaction carries a destination pixel (dst_row, dst_col). The
// block maps it through a projective transform set by eight signed Q16.32
// coefficient registers and returns one output transaction with the pixel, the
// source row and column (truncated toward zero) and an in_range flag. Source
// fields are zero whenever in_range is low, including a zero denominator.
// Coefficients are written through the cfg channel (cfg_ready is always high)
// and should only change while no transaction is in flight.
// Throughput is one transaction per clock while the receiver does not stall.
// The path from input acceptance to out_valid runs through sixteen register
// stages, of which the first loads at the accepting edge: three front stages
// (products, sums, magnitudes), twelve division cells each resolving one
// quotient bit, and an output register. When the receiver stalls, the whole
// pipeline holds and in_stall rises while a result is waiting and stalled.
// Synchronous reset empties the pipeline and restores the identity transform.
module perspective_warp_source_address (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pwsa_pkg::COORD_W-1:0]      dst_row,
  input  logic [pwsa_pkg::COORD_W-1:0]      dst_col,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pwsa_pkg::COEF_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pwsa_pkg::COORD_W-1:0]      out_dst_row,
  output logic [pwsa_pkg::COORD_W-1:0]      out_dst_col,
  output logic [pwsa_pkg::COORD_W-1:0]      src_row,
  output logic [pwsa_pkg::COORD_W-1:0]      src_col,
  output logic                              in_range
);
  import pwsa_pkg::*;

  pwsa_coef_t coef;
  logic en;
  logic chain_valid [QUOT_W+1];
  pwsa_div_t chain_data [QUOT_W+1];
  pwsa_div_t last;
  logic ok_r, ok_c, ok;

  // The pipeline advances unless a finished result is held by the receiver.
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Coefficient registers; writes to indexes beyond the list are dropped.
  // Reset loads unity on the two diagonal weights and zero elsewhere.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= (i == int'(REG_ROW_FROM_ROW) || i == int'(REG_COL_FROM_COL)) ?
                   COEF_W'(64'd4294967296) : '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_index <= REG_PERSP_FROM_COL) begin
      coef[cfg_index[2:0]] <= cfg_data;
    end
  end

  pwsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .row       (dst_row),
    .col       (dst_col),
    .coef      (coef),
    .out_valid (chain_valid[0]),
    .out_data  (chain_data[0])
  );

  // The divider is a row of identical cells, most significant quotient bit first.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
    pwsa_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  // A negative quotient is only acceptable when it truncates to zero.
  always_comb begin
    last = chain_data[QUOT_W];
    ok_r = !last.tag.r_ovf && (!last.tag.r_neg || last.q_r == '0) && last.q_r <= ROW_LAST;
    ok_c = !last.tag.c_ovf && (!last.tag.c_neg || last.q_c == '0) && last.q_c <= COL_LAST;
    ok   = !last.tag.dz && ok_r && ok_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dst_row <= last.tag.row;
      out_dst_col <= last.tag.col;
      src_row     <= ok ? last.q_r[COORD_W-1:0] : '0;
      src_col     <= ok ? last.q_c[COORD_W-1:0] : '0;
      in_range    <= ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain_valid[QUOT_W];
    end
  end

`ifndef ASSERT_OFF
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> src_row == '0 && src_col == '0)
    else $error("source fields nonzero while out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
`endif

endmodule

// ===== sim/perspective_warp_source_address_tb.sv =====
// Self-checking testbench for the perspective warp source address generator.
`timescale 1ns / 100ps

module perspective_warp_source_address_tb;
  import pwsa_pkg::*;

  // Register indexes, in the order of the coefficient bank.
  typedef enum logic [CFG_IDX_W-1:0] {
    R_ROW_FROM_ROW   = 4'd0,
    R_ROW_FROM_COL   = 4'd1,
    R_ROW_OFFSET     = 4'd2,
    R_COL_FROM_ROW   = 4'd3,
    R_COL_FROM_COL   = 4'd4,
    R_COL_OFFSET     = 4'd5,
    R_PERSP_FROM_ROW = 4'd6,
    R_PERSP_FROM_COL = 4'd7,
    R_UNUSED_A       = 4'd8,
    R_UNUSED_B       = 4'd15
  } coef_reg_e;

  localparam longint Q_UNIT = 64'sd4294967296;
  localparam int PIPE_DEPTH = 16;

  // One mapped pixel as seen on the output port.
  typedef struct packed {
    logic [COORD_W-1:0] drow;
    logic [COORD_W-1:0] dcol;
    logic [COORD_W-1:0] srow;
    logic [COORD_W-1:0] scol;
    logic               hit;
  } warp_result_t;

  // Holds the coefficient bank and the queue of predicted mappings.
  class warp_scoreboard;
    logic signed [COEF_W-1:0] coef [NUM_REGS];
    warp_result_t pending [$];
    int errors;
    int checked;
    int hits;
    int zero_dens;

    function void restore_identity();
      foreach (coef[i]) coef[i] = '0;
      coef[R_ROW_FROM_ROW] = COEF_W'(Q_UNIT);
      coef[R_COL_FROM_COL] = COEF_W'(Q_UNIT);
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
      if (idx < NUM_REGS) coef[idx] = val;
    endfunction

    // Predict the mapping of one accepted pixel. The sums fit in 64 bits and
    // SystemVerilog signed division truncates toward zero, as required.
    function void note_pixel(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      longint ri, ci, den, nr, nc, qr, qc;
      warp_result_t res;
      ri = longint'({1'b0, r});
      ci = longint'({1'b0, c});
      den = longint'(coef[R_PERSP_FROM_ROW]) * ri
          + longint'(coef[R_PERSP_FROM_COL]) * ci + Q_UNIT;
      nr = longint'(coef[R_ROW_FROM_ROW]) * ri
         + longint'(coef[R_ROW_FROM_COL]) * ci + longint'(coef[R_ROW_OFFSET]);
      nc = longint'(coef[R_COL_FROM_ROW]) * ri
         + longint'(coef[R_COL_FROM_COL]) * ci + longint'(coef[R_COL_OFFSET]);
      res = '0;
      res.drow = r;
      res.dcol = c;
      if (den == 0) begin
        zero_dens++;
      end else begin
        qr = nr / den;
        qc = nc / den;
        if (qr >= 0 && qr <= IMG_ROWS - 1 && qc >= 0 && qc <= IMG_COLS - 1) begin
          res.srow = COORD_W'(qr);
          res.scol = COORD_W'(qc);
          res.hit = 1'b1;
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(warp_result_t got);
      warp_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output transaction %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.hit) hits++;
      if (got.drow !== exp_r.drow) begin
        $display("%0t: out_dst_row expected %0d actual %0d", $time, exp_r.drow, got.drow);
        errors++;
      end
      if (got.dcol !== exp_r.dcol) begin
        $display("%0t: out_dst_col expected %0d actual %0d", $time, exp_r.dcol, got.dcol);
        errors++;
      end
      if (got.srow !== exp_r.srow) begin
        $display("%0t: src_row expected %0d actual %0d", $time, exp_r.srow, got.srow);
        errors++;
      end
      if (got.scol !== exp_r.scol) begin
        $display("%0t: src_col expected %0d actual %0d", $time, exp_r.scol, got.scol);
        errors++;
      end
      if (got.hit !== exp_r.hit) begin
        $display("%0t: in_range expected %0b actual %0b", $time, exp_r.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_W-1:0] dst_row = '0;
  logic [COORD_W-1:0] dst_col = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COORD_W-1:0] out_dst_row, out_dst_col, src_row, src_col;
  logic in_range;

  // Idle percentage on each side; zero gives a stretch at full rate.
  int idle_pct = 12;
  int pixels_sent;
  warp_scoreboard sb;

  always #5 clk = ~clk;

  perspective_warp_source_address u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .dst_row(dst_row), .dst_col(dst_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dst_row(out_dst_row), .out_dst_col(out_dst_col),
    .src_row(src_row), .src_col(src_col), .in_range(in_range)
  );

  // Receiver: checks every accepted output transaction and stalls at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        sb.check_result({out_dst_row, out_dst_col, src_row, src_col, in_range});
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Present one pixel and hold it until the block takes it. Idle cycles are
  // inserted ahead of the transaction, so valid never follows the stall.
  task automatic send_pixel(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dst_row <= r;
    dst_col <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(r, c);
    pixels_sent++;
  endtask

  // Wait for every predicted result, then let the pipeline drain fully so a
  // coefficient write cannot land on a transaction still in flight.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // One write, after which cfg_valid is dropped so the channel goes idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_coef(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_bank(input longint v0, v1, v2, v3, v4, v5, v6, v7);
    write_reg(R_ROW_FROM_ROW, COEF_W'(v0));
    write_reg(R_ROW_FROM_COL, COEF_W'(v1));
    write_reg(R_ROW_OFFSET, COEF_W'(v2));
    write_reg(R_COL_FROM_ROW, COEF_W'(v3));
    write_reg(R_COL_FROM_COL, COEF_W'(v4));
    write_reg(R_COL_OFFSET, COEF_W'(v5));
    write_reg(R_PERSP_FROM_ROW, COEF_W'(v6));
    write_reg(R_PERSP_FROM_COL, COEF_W'(v7));
  endtask

  function automatic logic [COEF_W-1:0] rand_coef();
    return COEF_W'({$urandom(), $urandom()});
  endfunction

  // A small coefficient near a useful scale: offset from centre in [-span, span]
  // units of 2^-16, so warps stay mostly inside the image.
  function automatic longint near(longint centre, int span);
    return centre + (longint'($urandom_range(2 * span)) - span) * 65536;
  endfunction

  task automatic random_pixels(input int n);
    repeat (n) send_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
  endtask

  localparam longint C_MAX = 64'sd140737488355327;
  localparam longint C_MIN = -64'sd140737488355328;

  initial begin
    sb = new();
    sb.restore_identity();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity transform after reset: corners and edges of the field range.
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
    wait_drained();

    // Zero denominator: den = -2^32/512 * 512 + 2^32, vanishing at row 512.
    write_reg(R_PERSP_FROM_ROW, COEF_W'(-Q_UNIT / 512));
    send_pixel(10'd512, 10'd7);
    send_pixel(10'd511, 10'd7);
    send_pixel(10'd513, 10'd7);
    wait_drained();

    // Small negative quotient: an offset of -0.5 truncates to zero, -1 leaves
    // the image. Unknown indexes and high data bits are written too.
    write_reg(R_PERSP_FROM_ROW, '0);
    write_reg(R_ROW_OFFSET, COEF_W'(-Q_UNIT / 2));
    write_reg(R_COL_OFFSET, COEF_W'(-Q_UNIT));
    write_reg(R_UNUSED_A, '1);
    write_reg(R_UNUSED_B, 48'h8000_0000_0000);
    send_pixel(10'd0, 10'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd5, 10'd1023);
    wait_drained();

    // Extreme coefficients: every register at its most positive, then its most
    // negative value.
    write_bank(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd0);
    wait_drained();
    write_bank(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd0, 10'd1);
    wait_drained();

    // Random phases. Most use mild warps so many pixels land inside the image;
    // one phase runs with no idling, and one uses arbitrary coefficients.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) begin
        for (int i = 0; i < NUM_REGS; i++)
          write_reg(CFG_IDX_W'(i), rand_coef());
      end else begin
        write_bank(near(Q_UNIT / 2, 20000), near(0, 15000), near(Q_UNIT * 100, 30000),
                   near(0, 15000), near(Q_UNIT / 2, 20000), near(Q_UNIT * 100, 30000),
                   near(0, 3), near(0, 3));
      end
      idle_pct = (ph == 2) ? 0 : 12;
      random_pixels(48);
      wait_drained();
    end
    idle_pct = 12;

    // Back to the identity bank with the sender held off until all is drained.
    write_bank(Q_UNIT, 0, 0, 0, Q_UNIT, 0, 0, 0);
    random_pixels(10);
    wait_drained();
    random_pixels(10);
    wait_drained();

    $display("Sent %0d pixels, checked %0d results: %0d inside the image, %0d zero denominators.",
             pixels_sent, sb.checked, sb.hits, sb.zero_dens);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("perspective_warp_source_address: match");
    else
      $display("perspective_warp_source_address: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #5ms;
    $display("perspective_warp_source_address: mismatch");
    $finish;
  end

endmodule
